/* src/sld_pkg.sv */
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; the interfaces and all modules reference this package.
package sld_pkg;

    localparam int ByteW  = 8;
    localparam int IndexW = 17;
    localparam int MaxW   = 17;

    localparam logic [ByteW-1:0]  SyncByte        = 8'h7E;
    localparam logic [IndexW-1:0] HeaderPlusCheck = 17'd6;
    localparam logic [IndexW-1:0] PayloadStart    = 17'd5;
    localparam logic [MaxW-1:0]   MaxLenReset     = 17'd1024;

    localparam logic [IndexW-1:0] IdxSync1  = 17'd0;
    localparam logic [IndexW-1:0] IdxSync2  = 17'd1;
    localparam logic [IndexW-1:0] IdxType   = 17'd2;
    localparam logic [IndexW-1:0] IdxLenLo  = 17'd3;
    localparam logic [IndexW-1:0] IdxLenHi  = 17'd4;

    typedef enum logic [5:0] {
        PH_HUNT1  = 6'b000001,
        PH_HUNT2  = 6'b000010,
        PH_TYPE   = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_LEN_HI = 6'b010000,
        PH_BODY   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_IN_FRAME = 2'd0,
        ST_GOOD     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_BAD_SUM  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ByteW-1:0]  frame_byte;
        logic [IndexW-1:0] byte_index;
        logic              frame_end;
        t_status           frame_status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_parse_out;

endpackage

/* src/sld_ifs.sv */
// Valid/ready channel interfaces for the deframer: received bytes,
// echoed frame bytes and the max-length configuration write. Uses sld_pkg.
interface sld_rx_if;
    logic                     valid;
    logic                     ready;
    logic [sld_pkg::ByteW-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_frame_if;
    logic                      valid;
    logic                      ready;
    logic [sld_pkg::ByteW-1:0]  frame_byte;
    logic [sld_pkg::IndexW-1:0] byte_index;
    logic                      frame_end;
    logic [1:0]                frame_status;
    modport source (output valid, output frame_byte, output byte_index,
                    output frame_end, output frame_status, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input frame_end, input frame_status, output ready);
endinterface

interface sld_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [sld_pkg::MaxW-1:0] max_frame_length;
    modport source (output valid, output max_frame_length, input ready);
    modport sink   (input valid, input max_frame_length, output ready);
endinterface

/* src/sld_parse.sv */
// Frame parser: phase machine, length latch, position counter and checksum.
// Processes one byte per step and presents its result combinationally. Uses sld_pkg.
module sld_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [sld_pkg::ByteW-1:0]  i_byte,
    input  logic [sld_pkg::MaxW-1:0]   i_max_len,
    output sld_pkg::t_parse_out        o_out
);

    sld_pkg::t_phase            r_phase, n_phase;
    logic [sld_pkg::ByteW-1:0]  r_len_low, n_len_low;
    logic [sld_pkg::IndexW-1:0] r_total, n_total;
    logic [sld_pkg::IndexW-1:0] r_pos, n_pos;
    logic [sld_pkg::ByteW-1:0]  r_sum, n_sum;
    logic [sld_pkg::IndexW-1:0] w_total;
    logic [sld_pkg::IndexW-1:0] w_pos_next;
    logic                       w_is_sync;

    assign w_is_sync  = (i_byte == sld_pkg::SyncByte);
    assign w_total    = {1'b0, i_byte, r_len_low} + sld_pkg::HeaderPlusCheck;
    assign w_pos_next = r_pos + 17'd1;

    always_comb begin
        n_phase   = r_phase;
        n_len_low = r_len_low;
        n_total   = r_total;
        n_pos     = r_pos;
        n_sum     = r_sum;
        o_out.valid            = 1'b0;
        o_out.res.frame_byte   = i_byte;
        o_out.res.byte_index   = sld_pkg::IdxSync1;
        o_out.res.frame_end    = 1'b0;
        o_out.res.frame_status = sld_pkg::ST_IN_FRAME;
        case (r_phase)
            sld_pkg::PH_HUNT2: begin
                if (w_is_sync) begin
                    n_phase              = sld_pkg::PH_TYPE;
                    o_out.valid          = 1'b1;
                    o_out.res.byte_index = sld_pkg::IdxSync2;
                end
            end
            sld_pkg::PH_TYPE: begin
                n_sum                = i_byte;
                n_phase              = sld_pkg::PH_LEN_LO;
                o_out.valid          = 1'b1;
                o_out.res.byte_index = sld_pkg::IdxType;
            end
            sld_pkg::PH_LEN_LO: begin
                n_len_low            = i_byte;
                n_sum                = r_sum + i_byte;
                n_phase              = sld_pkg::PH_LEN_HI;
                o_out.valid          = 1'b1;
                o_out.res.byte_index = sld_pkg::IdxLenLo;
            end
            sld_pkg::PH_LEN_HI: begin
                n_sum                = r_sum + i_byte;
                n_total              = w_total;
                o_out.valid          = 1'b1;
                o_out.res.byte_index = sld_pkg::IdxLenHi;
                if (w_total > i_max_len) begin
                    // abort: too long, restart the hunt
                    n_phase                = sld_pkg::PH_HUNT1;
                    o_out.res.frame_end    = 1'b1;
                    o_out.res.frame_status = sld_pkg::ST_TOO_LONG;
                end else begin
                    n_pos   = sld_pkg::PayloadStart;
                    n_phase = sld_pkg::PH_BODY;
                end
            end
            sld_pkg::PH_BODY: begin
                o_out.valid          = 1'b1;
                o_out.res.byte_index = r_pos;
                if (w_pos_next < r_total) begin
                    n_sum = r_sum + i_byte;
                    n_pos = w_pos_next;
                end else begin
                    // last byte is the checksum
                    n_phase                = sld_pkg::PH_HUNT1;
                    o_out.res.frame_end    = 1'b1;
                    o_out.res.frame_status = (i_byte == r_sum) ? sld_pkg::ST_GOOD
                                                               : sld_pkg::ST_BAD_SUM;
                end
            end
            default: begin
                if (w_is_sync) begin
                    n_phase     = sld_pkg::PH_HUNT2;
                    o_out.valid = 1'b1;
                end else begin
                    n_phase = sld_pkg::PH_HUNT1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sld_pkg::PH_HUNT1;
            r_len_low <= '0;
            r_total   <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_len_low <= n_len_low;
            r_total   <= n_total;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
        end
    end

endmodule

/* src/sync_length_checksum_deframer.sv */
// Top level of the double-sync, length-framed deframer with additive checksum.
// Depends on sld_pkg, the channel interfaces in sld_ifs.sv and sld_parse.
//
//   channel   dir  payload                                        beat taken when
//   i_rx      in   rx_byte[7:0]                                   valid & ready
//   o_frame   out  frame_byte, byte_index[16:0], frame_end,       valid & ready
//                  frame_status[1:0]
//   i_cfg     in   max_frame_length[16:0]                         valid & ready
//
// One byte per cycle while o_frame is not stalled; a byte's result is loaded into the
// result register after its beat, via the input register and then the parse logic.
// Synchronous active-low reset: hunt for first sync, max_frame_length = 1024.
// A stalled o_frame holds its beat; bytes that produce no result keep flowing past it.
// i_cfg is always ready.
module sync_length_checksum_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sld_rx_if.sink      i_rx,
    sld_frame_if.source o_frame,
    sld_cfg_if.sink     i_cfg
);

    logic                      r_in_valid;
    logic [sld_pkg::ByteW-1:0] r_in_byte;
    logic [sld_pkg::MaxW-1:0]  r_max_len;
    logic                      r_out_valid;
    sld_pkg::t_result          r_out;
    sld_pkg::t_parse_out       w_parse;
    logic                      w_out_free;
    logic                      w_step;

    assign w_out_free = !r_out_valid || o_frame.ready;
    // process the held byte when its result (if any) has somewhere to go
    assign w_step     = r_in_valid && (!w_parse.valid || w_out_free);
    assign i_rx.ready = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    sld_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_out     (w_parse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sld_pkg::MaxLenReset;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.max_frame_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_parse.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_parse.valid) begin
            r_out <= w_parse.res;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_byte   = r_out.frame_byte;
    assign o_frame.byte_index   = r_out.byte_index;
    assign o_frame.frame_end    = r_out.frame_end;
    assign o_frame.frame_status = r_out.frame_status;

endmodule

/* bench/testbench.sv */
// Self-checking bench for sync_length_checksum_deframer: random framed byte streams,
// a scoreboard class that predicts each echoed frame byte, and random stalls on both sides.
// Depends on sld_pkg, the channel interfaces in sld_ifs.sv and the deframer RTL.
module testbench;
    import sld_pkg::*;

    localparam int WatchdogLimit  = 5000;
    localparam int LongHoldCycles = 400;
    localparam int BytesPerStep   = 130;
    localparam int NumSteps       = 10;

    class frame_scoreboard;
        t_result           expected_q[$];
        logic [MaxW-1:0]   max_len;
        t_phase            ph;
        logic [ByteW-1:0]  len_lo;
        logic [ByteW-1:0]  sum;
        logic [IndexW-1:0] total;
        logic [IndexW-1:0] pos;
        int                errors;

        function new();
            max_len = MaxLenReset;
            ph      = PH_HUNT1;
            len_lo  = '0;
            sum     = '0;
            total   = '0;
            pos     = '0;
            errors  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the deframer state by one received byte; queue the echo it causes.
        function void note_byte(logic [ByteW-1:0] b);
            t_result r;
            bit      echoed;
            echoed         = 1'b1;
            r.frame_byte   = b;
            r.byte_index   = '0;
            r.frame_end    = 1'b0;
            r.frame_status = ST_IN_FRAME;
            case (ph)
                PH_HUNT2: begin
                    if (b == SyncByte) begin
                        ph = PH_TYPE;
                        r.byte_index = IdxSync2;
                    end else begin
                        echoed = 1'b0;
                    end
                end
                PH_TYPE: begin
                    sum = b;
                    ph = PH_LEN_LO;
                    r.byte_index = IdxType;
                end
                PH_LEN_LO: begin
                    len_lo = b;
                    sum = sum + b;
                    ph = PH_LEN_HI;
                    r.byte_index = IdxLenLo;
                end
                PH_LEN_HI: begin
                    sum = sum + b;
                    total = {1'b0, b, len_lo} + HeaderPlusCheck;
                    r.byte_index = IdxLenHi;
                    if (total > max_len) begin
                        ph = PH_HUNT1;
                        r.frame_end = 1'b1;
                        r.frame_status = ST_TOO_LONG;
                    end else begin
                        pos = PayloadStart;
                        ph = PH_BODY;
                    end
                end
                PH_BODY: begin
                    r.byte_index = pos;
                    if (pos + 17'd1 < total) begin
                        sum = sum + b;
                        pos = pos + 17'd1;
                    end else begin
                        ph = PH_HUNT1;
                        r.frame_end = 1'b1;
                        if (b == sum) begin
                            r.frame_status = ST_GOOD;
                        end else begin
                            r.frame_status = ST_BAD_SUM;
                        end
                    end
                end
                default: begin
                    if (b == SyncByte) begin
                        ph = PH_HUNT2;
                        r.byte_index = IdxSync1;
                    end else begin
                        ph = PH_HUNT1;
                        echoed = 1'b0;
                    end
                end
            endcase
            if (echoed) begin
                expected_q.push_back(r);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) begin
                $display("ERROR: %s", msg);
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: byte %h index %0d end %b status %0d",
                    got.frame_byte, got.byte_index, got.frame_end, got.frame_status));
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index ||
                got.frame_end !== want.frame_end || got.frame_status !== want.frame_status) begin
                report_mismatch($sformatf(
                    "got byte %h index %0d end %b status %0d, want %h %0d %b %0d",
                    got.frame_byte, got.byte_index, got.frame_end, got.frame_status,
                    want.frame_byte, want.byte_index, want.frame_end, want.frame_status));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #10 i_clk = ~i_clk;

    sld_rx_if    rx_if ();
    sld_frame_if frame_if ();
    sld_cfg_if   cfg_if ();

    sync_length_checksum_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if),
        .i_cfg   (cfg_if)
    );

    frame_scoreboard  sb;
    logic [ByteW-1:0] stim_q[$];
    int               cur_max = 1024;
    int               rx_gap_pct = 0;
    int               ready_gap_pct = 0;
    bit               hold_req = 1'b0;
    int               idle_cycles = 0;
    logic [MaxW-1:0]  max_steps [NumSteps] = '{17'd0, 17'd5, 17'd6, 17'd7, 17'd10, 17'd1024,
                                               17'd65540, 17'd65541, 17'h1FFFF, 17'd40};

    // Append one frame: full body and checksum, or the header alone when it is too long.
    function automatic void add_frame(logic [ByteW-1:0] typ, logic [15:0] len, bit full,
                                      bit bad_sum);
        logic [ByteW-1:0] s;
        logic [ByteW-1:0] b;
        stim_q.push_back(SyncByte);
        stim_q.push_back(SyncByte);
        stim_q.push_back(typ);
        stim_q.push_back(len[7:0]);
        stim_q.push_back(len[15:8]);
        s = typ + len[7:0] + len[15:8];
        if (!full) begin
            return;
        end
        for (int k = 0; k < len; k++) begin
            b = $urandom;
            s = s + b;
            stim_q.push_back(b);
        end
        if (bad_sum) begin
            s = s ^ (8'd1 << $urandom_range(0, 7));
        end
        stim_q.push_back(s);
    endfunction

    function automatic void build_stream(int target);
        int  kind;
        int  r;
        int  len;
        int  n;
        bit  fits;
        while (stim_q.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                repeat ($urandom_range(1, 4)) stim_q.push_back($urandom);
            end else if (kind < 18) begin
                // Truncated header: the next bytes land in whatever phase this leaves.
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    stim_q.push_back((k < 2) ? SyncByte : ByteW'($urandom));
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    len = 16'hFFFF;
                end else if (r < 8) begin
                    len = $urandom_range(0, 65535);
                end else if (r < 12) begin
                    len = $urandom_range(13, 300);
                end else if (r < 30 && cur_max >= 6 && cur_max <= 306) begin
                    len = cur_max - 6 + $urandom_range(0, 1);
                end else begin
                    len = $urandom_range(0, 12);
                end
                fits = (len + 6 <= cur_max);
                if (fits && len > 300) begin
                    len = $urandom_range(0, 12);
                end
                add_frame($urandom, len[15:0], fits, $urandom_range(0, 3) == 0);
            end
        end
    endfunction

    task automatic send_queued();
        while (stim_q.size() != 0) begin
            if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
                rx_if.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            rx_if.valid   <= 1'b1;
            rx_if.rx_byte <= stim_q.pop_front();
            do @(posedge i_clk); while (!rx_if.ready);
        end
        rx_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        // Let the monitor note the last accepted byte before the scoreboard is polled.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        // Let a trailing byte with no echo clear the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [MaxW-1:0] v);
        cfg_if.valid            <= 1'b1;
        cfg_if.max_frame_length <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_max = v;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                sb.note_byte(rx_if.rx_byte);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.max_len = cfg_if.max_frame_length;
            end
            if (frame_if.valid && frame_if.ready) begin
                got.frame_byte   = frame_if.frame_byte;
                got.byte_index   = frame_if.byte_index;
                got.frame_end    = frame_if.frame_end;
                got.frame_status = t_status'(frame_if.frame_status);
                sb.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (frame_if.valid && frame_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        frame_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // Hold off long enough for the block to back up into its input.
                frame_if.ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (ready_gap_pct != 0 && $urandom_range(0, 99) < ready_gap_pct) begin
                frame_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                frame_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : main
        sb = new();
        i_rst_n                 <= 1'b0;
        rx_if.valid             <= 1'b0;
        rx_if.rx_byte           <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.max_frame_length <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length limit: noise while hunting, empty frame with type zero,
        // bad checksum, and a header far beyond the limit.
        stim_q = '{8'h00, 8'hFF, SyncByte, 8'h12, SyncByte, 8'h00, 8'h00, 8'h00, 8'h00,
                   SyncByte, SyncByte, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00,
                   SyncByte, SyncByte, 8'h01, 8'hFF, 8'hFF};
        send_queued();

        for (int i = 0; i < NumSteps; i++) begin
            wait_drained();
            if (i == NumSteps - 1) begin
                write_max_len($urandom_range(6, 300));
            end else begin
                write_max_len(max_steps[i]);
            end
            rx_gap_pct    = (i >= NumSteps - 2 || i % 3 == 2) ? 0 : 30;
            ready_gap_pct = (i >= NumSteps - 2 || i % 3 == 1) ? 0 : 30;
            if (i == 5) begin
                hold_req = 1'b1;
            end
            build_stream(BytesPerStep);
            send_queued();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/sld_pkg.sv
src/sld_ifs.sv
src/sld_parse.sv
src/sync_length_checksum_deframer.sv
bench/testbench.sv
